[rtl/ppid_pkg.sv]
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared widths, reset values and register indexes of the positional PID.
// ----------------------------------------------------------------------------
package ppid_pkg;

	localparam int DATA_W     = 16;                  // setpoint, measured, drive
	localparam int ERR_W      = DATA_W + 1;          // setpoint - measured
	localparam int GAIN_W     = 16;                  // unsigned Q8.8 gains
	localparam int LIM_W      = 15;                  // clamp magnitudes
	localparam int FRAC_W     = 8;                   // fraction bits of the sums
	localparam int INT_W      = LIM_W + FRAC_W + 1;  // clamped integral, signed
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [LIM_W-1:0] LIM_RESET = {LIM_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4
	} cfg_reg_t;

endpackage

[rtl/ppid_sample_if.sv]
// ----------------------------------------------------------------------------
// ppid_sample_if
// Sample channel: setpoint and measured value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppid_sample_if;

	logic                                  valid;
	logic                                  ready;
	logic signed [ppid_pkg::DATA_W-1:0]    setpoint;
	logic signed [ppid_pkg::DATA_W-1:0]    measured;

	modport source (output valid, output setpoint, output measured, input ready);
	modport sink   (input valid, input setpoint, input measured, output ready);

endinterface

[rtl/ppid_drive_if.sv]
// ----------------------------------------------------------------------------
// ppid_drive_if
// Result channel: clamped drive value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppid_drive_if;

	logic                                  valid;
	logic                                  ready;
	logic signed [ppid_pkg::DATA_W-1:0]    drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);

endinterface

[rtl/positional_pid_clamped.sv]
// ----------------------------------------------------------------------------
// positional_pid_clamped
// Positional PID with a symmetric integral clamp and a symmetric output clamp.
// ----------------------------------------------------------------------------
// An accepted sample passes the stage 1 product registers, then drive_s2.
// Throughput: one sample per cycle while the result is taken; the integral
// add and clamp close their loop within stage 2, the three multipliers sit
// in stage 1. A stalled result still lets one more sample enter stage 1.
// Reset: gains clear to 0, both limits go to 32767, integral and previous
// error clear to 0, both stages empty.
module positional_pid_clamped (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [ppid_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [ppid_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	ppid_sample_if.sink                          sample,
	ppid_drive_if.source                         result
);

	// configuration
	logic [ppid_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [ppid_pkg::LIM_W-1:0]  integral_limit_q, output_limit_q;

	// controller state
	logic signed [16:0] prev_error_q;
	logic signed [23:0] integ_q;

	// stage 1: products
	logic               valid_s1;
	logic signed [32:0] prod_p_s1, prod_i_s1;
	logic signed [33:0] prod_d_s1;

	// stage 2: output register
	logic               valid_s2;
	logic signed [15:0] drive_s2;

	logic adv_s1, adv_s2, take_s2;

	logic signed [16:0] err_c;
	logic signed [17:0] diff_c;
	logic signed [32:0] prod_p_c, prod_i_c;
	logic signed [33:0] prod_d_c;

	logic signed [33:0] integ_ext, prod_i_ext, integ_sum, ilim_34, integ_cl;
	logic signed [35:0] sum_c;
	logic signed [27:0] scaled_c, olim_28, drive_cl;
	logic signed [23:0] ilim_s;
	logic signed [15:0] olim_s;

	// handshake
	assign take_s2      = !valid_s2 || result.ready;
	assign adv_s1       = sample.valid && sample.ready;
	assign adv_s2       = valid_s1 && take_s2;
	assign sample.ready = !valid_s1 || take_s2;
	assign result.valid = valid_s2;
	assign result.drive = drive_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= ppid_pkg::LIM_RESET;
			output_limit_q   <= ppid_pkg::LIM_RESET;
		end else if (cfg_wen) begin
			case (ppid_pkg::cfg_reg_t'(cfg_idx))
				ppid_pkg::REG_GAIN_P:         gain_p_q         <= cfg_wdata;
				ppid_pkg::REG_GAIN_I:         gain_i_q         <= cfg_wdata;
				ppid_pkg::REG_GAIN_D:         gain_d_q         <= cfg_wdata;
				ppid_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_wdata[14:0];
				ppid_pkg::REG_OUTPUT_LIMIT:   output_limit_q   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// stage 1: error, difference and the three gain products
	always_comb begin
		err_c    = {sample.setpoint[15], sample.setpoint} -
		           {sample.measured[15], sample.measured};
		diff_c   = {err_c[16], err_c} - {prev_error_q[16], prev_error_q};
		prod_p_c = err_c * $signed({1'b0, gain_p_q});
		prod_i_c = err_c * $signed({1'b0, gain_i_q});
		prod_d_c = diff_c * $signed({1'b0, gain_d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			prev_error_q <= '0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (adv_s1)
				prev_error_q <= err_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prod_p_s1 <= prod_p_c;
			prod_i_s1 <= prod_i_c;
			prod_d_s1 <= prod_d_c;
		end
	end

	// stage 2: integral update and clamp, sum, floor shift, output clamp
	always_comb begin
		ilim_s     = {1'b0, integral_limit_q, 8'b0};
		olim_s     = {1'b0, output_limit_q};
		integ_ext  = {{10{integ_q[23]}}, integ_q};
		prod_i_ext = {prod_i_s1[32], prod_i_s1};
		ilim_34    = {11'b0, integral_limit_q, 8'b0};
		integ_sum  = integ_ext + prod_i_ext;
		if (integ_sum > ilim_34)
			integ_cl = ilim_34;
		else if (integ_sum < -ilim_34)
			integ_cl = -ilim_34;
		else
			integ_cl = integ_sum;

		sum_c = {{3{prod_p_s1[32]}}, prod_p_s1} +
		        {{2{prod_d_s1[33]}}, prod_d_s1} +
		        {{12{integ_cl[23]}}, integ_cl[23:0]};
		// arithmetic shift floors toward minus infinity
		scaled_c = sum_c[35:8];
		olim_28  = {13'b0, output_limit_q};
		if (scaled_c > olim_28)
			drive_cl = olim_28;
		else if (scaled_c < -olim_28)
			drive_cl = -olim_28;
		else
			drive_cl = scaled_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			integ_q  <= '0;
		end else begin
			if (take_s2)
				valid_s2 <= valid_s1;
			if (adv_s2)
				integ_q <= integ_cl[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2)
			drive_s2 <= drive_cl[15:0];
	end

	// ------------------------------------------------------------------------
	a_integ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> (integ_q <= $past(ilim_s)) && (integ_q >= -$past(ilim_s)))
		else $error("integral left its clamp range");

	a_drive_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> (drive_s2 <= $past(olim_s)) && (drive_s2 >= -$past(olim_s)))
		else $error("drive left its clamp range");

	a_prev_error: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> prev_error_q == $past(err_c))
		else $error("previous error not taken from accepted sample");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !result.ready) |-> !sample.ready)
		else $error("sample accepted while both stages are stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && take_s2) |=> valid_s2)
		else $error("stage 1 item lost on advance");

endmodule
